// File: design/rid_pkg.sv
// ----------------------------------------------------------------------------
// rid_pkg
// Shared types, codes and defaults of the rotary indexer controller: the item
// and result formats, the request kinds, the configuration register indexes,
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package rid_pkg;

  // Fixed field widths.
  localparam int TUBE_W  = 4;
  localparam int SPR_W   = 16;
  localparam int MICRO_W = 9;
  localparam int SPAN_W  = 16;
  localparam int SWEEP_W = SPAN_W + 1;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Defaults for the top-level parameters.
  localparam int DEF_POSITIONS  = 12;
  localparam int DEF_MOVE_WIDTH = 32;

  // Reset values of the configuration registers.
  localparam logic [SPR_W-1:0]   SPR_RESET   = SPR_W'(200);
  localparam logic [MICRO_W-1:0] MICRO_RESET = MICRO_W'(50);
  localparam logic [SPAN_W-1:0]  SPAN_RESET  = SPAN_W'(2200);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_STEPS_PER_REV    = 2'd0,
    CFG_MICROSTEP_FACTOR = 2'd1,
    CFG_HALF_SPAN        = 2'd2
  } cfg_index_t;

  // Request kinds carried by an input item.
  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_SELECT = 2'd1,
    KIND_HOME   = 2'd2
  } kind_t;

  // One input request.
  typedef struct packed {
    logic [1:0]        kind;
    logic [TUBE_W-1:0] tube;
    logic              center_sensor;
    logic              home_sensor;
  } item_t;

  // One result.
  typedef struct packed {
    logic              step_pulse;
    logic              step_dir;
    logic              motor_enable;
    logic              select_done;
    logic [TUBE_W-1:0] selected_tube;
    logic              center_found;
    logic              busy_res;
  } result_t;

  // Datapath operations on the move counter.
  typedef enum logic [1:0] {
    STEPS_HOLD  = 2'd0,
    STEPS_DEC   = 2'd1,
    STEPS_CLEAR = 2'd2,
    STEPS_LOAD  = 2'd3
  } steps_op_t;

  // Datapath operations on the sweep counter.
  typedef enum logic [1:0] {
    SWEEP_HOLD  = 2'd0,
    SWEEP_CLEAR = 2'd1,
    SWEEP_INC   = 2'd2
  } sweep_op_t;

  // Datapath operations on the travel direction.
  typedef enum logic [1:0] {
    DIR_HOLD    = 2'd0,
    DIR_FORWARD = 2'd1,
    DIR_TARGET  = 2'd2
  } dir_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load_target;
    logic      calc_mul;
    logic      calc_div;
    steps_op_t steps_op;
    sweep_op_t sweep_op;
    dir_op_t   dir_op;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [TUBE_W-1:0] cur_pos;
    logic              sel_ok;
    logic              steps_zero;
    logic              travel_dir;
    logic              sweep_hit_span;
    logic              sweep_hit_double;
  } status_t;

endpackage

// File: design/rid_datapath.sv
// ----------------------------------------------------------------------------
// rid_datapath
// Configuration registers, position, move and sweep counters, and the
// three-stage step count calculation of a select request.
// ----------------------------------------------------------------------------
module rid_datapath import rid_pkg::*; #(
  parameter int POSITIONS  = DEF_POSITIONS,
  parameter int MOVE_WIDTH = DEF_MOVE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [TUBE_W-1:0]      tube,
  input  cmd_t                   cmd,
  output status_t                status
);

  localparam int DIST_W    = TUBE_W + 1;
  localparam int X_W       = TUBE_W + SPR_W;
  localparam int DIV_SHIFT = X_W + 6;
  localparam int RECIP_W   = DIV_SHIFT;
  localparam longint DIV_RECIP_L =
    ((longint'(1) <<< DIV_SHIFT) + longint'(POSITIONS) - 1) / longint'(POSITIONS);
  localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(DIV_RECIP_L);
  localparam int DPROD_W   = X_W + RECIP_W;
  localparam int SC_W      = X_W + MICRO_W;
  localparam int EXT_W     = (SC_W > MOVE_WIDTH) ? SC_W : MOVE_WIDTH;
  localparam logic [DIST_W-1:0] POS_COUNT = DIST_W'(POSITIONS);

  logic [SPR_W-1:0]      steps_per_rev;
  logic [MICRO_W-1:0]    microstep_factor;
  logic [SPAN_W-1:0]     half_span;
  logic [TUBE_W-1:0]     current_position;
  logic [MOVE_WIDTH-1:0] steps_left;
  logic                  travel_dir;
  logic [SWEEP_W-1:0]    sweep_count;
  logic [TUBE_W-1:0]     move_dist;
  logic [X_W-1:0]        dist_steps;
  logic [X_W-1:0]        quot;

  logic [TUBE_W-1:0]     diff_abs;
  logic [DIST_W-1:0]     diff_other;
  logic [TUBE_W-1:0]     dist_next;
  logic                  dir_next;
  logic [DPROD_W-1:0]    div_prod;
  logic [SC_W-1:0]       scaled;
  logic [EXT_W-1:0]      scaled_ext;
  logic [EXT_W-1:0]      move_max;
  logic [EXT_W-1:0]      move_sat;
  logic [SPAN_W-1:0]     span;
  logic [SWEEP_W-1:0]    sweep_inc;

  // Shorter way round from the current position to the requested one.
  always_comb begin
    diff_abs   = (tube > current_position) ? (tube - current_position)
                                           : (current_position - tube);
    diff_other = POS_COUNT - {1'b0, diff_abs};
    if (diff_other < {1'b0, diff_abs}) begin
      dist_next = diff_other[TUBE_W-1:0];
      dir_next  = (tube > current_position);
    end else begin
      dist_next = diff_abs;
      dir_next  = (tube < current_position);
    end
  end

  // Division by the position count as a multiply by its rounded-up reciprocal,
  // then scaling by the microstep factor with saturation to the move width.
  always_comb begin
    div_prod   = DPROD_W'(dist_steps) * DPROD_W'(DIV_RECIP);
    scaled     = SC_W'(quot) * SC_W'(microstep_factor);
    scaled_ext = EXT_W'(scaled);
    move_max   = EXT_W'({MOVE_WIDTH{1'b1}});
    move_sat   = (scaled_ext > move_max) ? move_max : scaled_ext;
  end

  // Sweep limits; a zero span counts as one step.
  always_comb begin
    span      = (half_span == '0) ? SPAN_W'(1) : half_span;
    sweep_inc = sweep_count + SWEEP_W'(1);
  end

  // Status back to the controller.
  always_comb begin
    status.cur_pos          = current_position;
    status.sel_ok           = ({1'b0, tube} < POS_COUNT) && (tube != current_position);
    status.steps_zero       = (steps_left == '0);
    status.travel_dir       = travel_dir;
    status.sweep_hit_span   = (sweep_inc >= {1'b0, span});
    status.sweep_hit_double = (sweep_inc >= {span, 1'b0});
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_rev    <= SPR_RESET;
      microstep_factor <= MICRO_RESET;
      half_span        <= SPAN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEPS_PER_REV:    steps_per_rev    <= cfg_data;
        CFG_MICROSTEP_FACTOR: microstep_factor <= cfg_data[MICRO_W-1:0];
        CFG_HALF_SPAN:        half_span        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Position, direction and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_position <= '0;
      steps_left       <= '0;
      travel_dir       <= 1'b0;
      sweep_count      <= '0;
    end else begin
      if (cmd.load_target) begin
        current_position <= tube;
      end
      case (cmd.dir_op)
        DIR_FORWARD: travel_dir <= 1'b0;
        DIR_TARGET:  travel_dir <= dir_next;
        default: ;
      endcase
      case (cmd.steps_op)
        STEPS_DEC:   steps_left <= steps_left - MOVE_WIDTH'(1);
        STEPS_CLEAR: steps_left <= '0;
        STEPS_LOAD:  steps_left <= move_sat[MOVE_WIDTH-1:0];
        default: ;
      endcase
      case (cmd.sweep_op)
        SWEEP_CLEAR: sweep_count <= '0;
        SWEEP_INC:   sweep_count <= sweep_inc;
        default: ;
      endcase
    end
  end

  // Step count calculation stages.
  always_ff @(posedge clk) begin
    if (cmd.load_target) begin
      move_dist <= dist_next;
    end
    if (cmd.calc_mul) begin
      dist_steps <= X_W'(move_dist) * X_W'(steps_per_rev);
    end
    if (cmd.calc_div) begin
      quot <= X_W'(div_prod >> DIV_SHIFT);
    end
  end

endmodule

// File: design/rid_ctrl.sv
// ----------------------------------------------------------------------------
// rid_ctrl
// Controller: input and result handshakes, the carousel activity (move,
// homing, three centre search sweeps), and the sequencer that steps the
// datapath through the step count calculation of a select request.
// ----------------------------------------------------------------------------
module rid_ctrl import rid_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [1:0] {
    SEQ_READY,
    SEQ_MUL,
    SEQ_DIV,
    SEQ_SCALE
  } seq_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_MOVE,
    MODE_SWEEP1,
    MODE_SWEEP2,
    MODE_SWEEP3,
    MODE_HOMING
  } mode_t;

  seq_t    seq, seq_next;
  mode_t   mode, mode_next;
  logic    homing_flag, homing_flag_next;
  logic    found_flag, found_flag_next;
  result_t res_next;
  logic    accept;

  // A new request is taken once the calculation is finished and the result
  // register is free or being emptied.
  assign item_stall = (seq != SEQ_READY) || (result_valid && result_stall);
  assign accept     = item_valid && !item_stall;

  // Request decode, activity update and result.
  always_comb begin
    logic  pulse;
    logic  dir;
    logic  done;
    logic  hit;
    mode_t m;

    cmd              = '0;
    seq_next         = seq;
    m                = mode;
    homing_flag_next = homing_flag;
    found_flag_next  = found_flag;
    pulse            = 1'b0;
    dir              = 1'b0;
    done             = 1'b0;
    hit              = 1'b0;

    case (seq)
      SEQ_READY: begin
        if (accept) begin
          case (item.kind)
            KIND_SELECT: begin
              if (status.sel_ok) begin
                cmd.load_target  = 1'b1;
                cmd.dir_op       = DIR_TARGET;
                cmd.sweep_op     = SWEEP_CLEAR;
                homing_flag_next = 1'b0;
                m                = MODE_MOVE;
                seq_next         = SEQ_MUL;
              end
            end
            KIND_HOME: begin
              m                = MODE_HOMING;
              homing_flag_next = 1'b1;
              cmd.sweep_op     = SWEEP_CLEAR;
              cmd.steps_op     = STEPS_CLEAR;
            end
            KIND_TICK: begin
              // Move and homing steps, and the hand-over to the centre search.
              case (mode)
                MODE_MOVE: begin
                  if (!status.steps_zero) begin
                    pulse        = 1'b1;
                    dir          = status.travel_dir;
                    cmd.steps_op = STEPS_DEC;
                  end else begin
                    m = MODE_SWEEP1;
                  end
                end
                MODE_HOMING: begin
                  pulse = 1'b1;
                  if (item.home_sensor) begin
                    cmd.dir_op   = DIR_FORWARD;
                    cmd.sweep_op = SWEEP_CLEAR;
                    m            = MODE_SWEEP1;
                  end
                end
                default: ;
              endcase

              // One centre search step; the sweep counter is zero on entry.
              if (!pulse && (m == MODE_SWEEP1 || m == MODE_SWEEP2 || m == MODE_SWEEP3)) begin
                pulse = 1'b1;
                dir   = status.travel_dir ^ (m == MODE_SWEEP2);
                hit   = (m == MODE_SWEEP2) ? status.sweep_hit_double
                                           : status.sweep_hit_span;
                if (!item.center_sensor || (hit && m == MODE_SWEEP3)) begin
                  found_flag_next  = !item.center_sensor;
                  done             = !homing_flag;
                  homing_flag_next = 1'b0;
                  cmd.sweep_op     = SWEEP_CLEAR;
                  m                = MODE_IDLE;
                end else if (hit) begin
                  cmd.sweep_op = SWEEP_CLEAR;
                  m            = (m == MODE_SWEEP1) ? MODE_SWEEP2 : MODE_SWEEP3;
                end else begin
                  cmd.sweep_op = SWEEP_INC;
                end
              end
            end
            default: ;
          endcase
        end
      end
      SEQ_MUL: begin
        cmd.calc_mul = 1'b1;
        seq_next     = SEQ_DIV;
      end
      SEQ_DIV: begin
        cmd.calc_div = 1'b1;
        seq_next     = SEQ_SCALE;
      end
      SEQ_SCALE: begin
        cmd.steps_op = STEPS_LOAD;
        seq_next     = SEQ_READY;
      end
      default: seq_next = SEQ_READY;
    endcase

    mode_next              = m;
    res_next.step_pulse    = pulse;
    res_next.step_dir      = dir;
    res_next.motor_enable  = pulse || (m != MODE_IDLE);
    res_next.select_done   = done;
    res_next.selected_tube = cmd.load_target ? item.tube : status.cur_pos;
    res_next.center_found  = found_flag_next;
    res_next.busy_res      = (m != MODE_IDLE);
  end

  // Sequencer, activity, flags and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq          <= SEQ_READY;
      mode         <= MODE_IDLE;
      homing_flag  <= 1'b0;
      found_flag   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      seq         <= seq_next;
      mode        <= mode_next;
      homing_flag <= homing_flag_next;
      found_flag  <= found_flag_next;
      if (accept) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
    if (accept) begin
      result <= res_next;
    end
  end

endmodule

// File: design/rotary_indexer_controller.sv
// ----------------------------------------------------------------------------
// rotary_indexer_controller
// Step sequencer for a carousel with a fixed number of positions.
// ----------------------------------------------------------------------------
// Requests arrive on the item channel (item_valid / item_stall / item): a
// tick, a select request or a homing request. Every request produces exactly
// one result on the result channel (result_valid / result_stall / result)
// with the step issued for it and the status after it.
// The result of a request is registered at the edge that takes the request,
// so it appears in the following cycle. Ticks can follow back to back while
// the result channel does not stall. A select request that starts a move
// holds item_stall high while, after the accepting cycle, the step count goes
// through a multiply by steps per revolution, a reciprocal multiply for the
// division by the position count and a multiply by the microstep factor.
// While a result waits under result_stall, item_stall stays high; nothing is
// dropped. Configuration writes use cfg_valid / cfg_ready / cfg_index /
// cfg_data, are always ready and must be issued only while the block is idle.
// A synchronous reset returns the carousel to position 0, idle, with the
// default configuration; no result is pending after reset.
// ----------------------------------------------------------------------------
module rotary_indexer_controller import rid_pkg::*; #(
  parameter int POSITIONS  = DEF_POSITIONS,
  parameter int MOVE_WIDTH = DEF_MOVE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cmd_t    cmd;
  status_t status;

  // Configuration writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  rid_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .status       (status),
    .cmd          (cmd)
  );

  rid_datapath #(
    .POSITIONS  (POSITIONS),
    .MOVE_WIDTH (MOVE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tube      (item.tube),
    .cmd       (cmd),
    .status    (status)
  );

  // The step count calculation runs its stages in order.
  assert property (@(posedge clk) disable iff (rst) cmd.calc_mul |=> cmd.calc_div)
    else $error("step count division did not follow the multiply");

  // No request is taken while the move counter is being loaded.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.steps_op == STEPS_LOAD) |-> item_stall)
    else $error("request taken during step count calculation");

  // A result without a step reports the forward direction.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.step_pulse || !result.step_dir))
    else $error("step direction set without a step");

  // A step always comes with the motor enabled.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.step_pulse) |-> result.motor_enable)
    else $error("step issued with motor disabled");

endmodule
